// ===== src/heightfield_span_merge_core_assert.svh =====
// Assertion helpers used by the span merge datapath.
`ifndef HEIGHTFIELD_SPAN_MERGE_CORE_ASSERT_SVH
`define HEIGHTFIELD_SPAN_MERGE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define HSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("span merge assertion failed");

// Next-cycle implication, disabled while reset is held.
`define HSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("span merge assertion failed");

`endif

// ===== src/hsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hsm_pkg;

    localparam logic       ACT_ADD  = 1'b0;
    localparam logic       ACT_READ = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_COL,
        S_CNT_RD,
        S_CNT_GET,
        S_DISPATCH,
        S_RD_ISSUE,
        S_RD_GET,
        S_WALK_RD,
        S_WALK_EVAL,
        S_CHECK,
        S_MOVE_RD,
        S_MOVE_WR,
        S_COMMIT,
        S_FINISH
    } t_state;

    // Which result the datapath latches into its working result registers.
    typedef enum logic [2:0] {
        RES_NONE,
        RES_EMPTY,
        RES_READ,
        RES_ORDER,
        RES_FULL,
        RES_ADD
    } t_res;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic col_calc;
        logic cnt_rd;
        logic cnt_get;
        logic span_rd;
        logic walk_eval;
        logic setup_move;
        logic move_wr;
        logic commit;
        logic out_load;
        t_res res;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic is_read;
        logic slot_empty;
        logic bad_order;
        logic cnt_zero;
        logic walk_done;
        logic full;
        logic move_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== src/heightfield_span_merge_core.sv =====
// Read request: the column count and then the span in the slot are read before the result is loaded.
// Add request: W = spans walked, M = spans moved, W + M at most
// MAX_SPANS + 1; a walk step reads then compares a span, a move step reads then writes one.
// Bottom above top or an empty read slot ends the request at dispatch, a full column after the walk.
// Synchronous reset: after it a clearing pass over all GRID_W*GRID_H columns zeroes the column
// counts while input is stalled; span contents are not cleared. merge_threshold resets to 1.
`timescale 1ns / 1ps
`default_nettype none

module heightfield_span_merge_core
    import hsm_pkg::*;
#(
    parameter int GRID_W      = 64,
    parameter int GRID_H      = 64,
    parameter int MAX_SPANS   = 8,
    parameter int HEIGHT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [9:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_action,
    input  wire logic [5:0]  i_col_x,
    input  wire logic [5:0]  i_col_z,
    input  wire logic [15:0] i_span_bottom,
    input  wire logic [15:0] i_span_top,
    input  wire logic [5:0]  i_area_id,
    input  wire logic [2:0]  i_slot,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [15:0]      o_out_bottom,
    output logic [15:0]      o_out_top,
    output logic [5:0]       o_out_area,
    output logic [2:0]       o_out_slot,
    output logic [3:0]       o_span_count
);

    t_cmd cmd;
    t_sts sts;

    // The threshold register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    hsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hsm_dpath #(
        .GRID_W      (GRID_W),
        .GRID_H      (GRID_H),
        .MAX_SPANS   (MAX_SPANS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_action      (i_action),
        .i_col_x       (i_col_x),
        .i_col_z       (i_col_z),
        .i_span_bottom (i_span_bottom),
        .i_span_top    (i_span_top),
        .i_area_id     (i_area_id),
        .i_slot        (i_slot),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_out_bottom  (o_out_bottom),
        .o_out_top     (o_out_top),
        .o_out_area    (o_out_area),
        .o_out_slot    (o_out_slot),
        .o_span_count  (o_span_count)
    );

endmodule

`default_nettype wire

// ===== src/hsm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/hsm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsm_ctrl
    import hsm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.res  = RES_NONE;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_COL;
                end
            end
            S_COL: begin
                o_cmd.col_calc = 1'b1;
                n_state        = S_CNT_RD;
            end
            S_CNT_RD: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = S_CNT_GET;
            end
            S_CNT_GET: begin
                o_cmd.cnt_get = 1'b1;
                n_state       = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (i_sts.is_read) begin
                    if (i_sts.slot_empty) begin
                        o_cmd.res = RES_EMPTY;
                        n_state   = S_FINISH;
                    end else begin
                        n_state = S_RD_ISSUE;
                    end
                end else if (i_sts.bad_order) begin
                    o_cmd.res = RES_ORDER;
                    n_state   = S_FINISH;
                end else if (i_sts.cnt_zero) begin
                    n_state = S_CHECK;
                end else begin
                    n_state = S_WALK_RD;
                end
            end
            S_RD_ISSUE: begin
                o_cmd.span_rd = 1'b1;
                n_state       = S_RD_GET;
            end
            S_RD_GET: begin
                o_cmd.res = RES_READ;
                n_state   = S_FINISH;
            end
            S_WALK_RD: begin
                o_cmd.span_rd = 1'b1;
                n_state       = S_WALK_EVAL;
            end
            S_WALK_EVAL: begin
                o_cmd.walk_eval = 1'b1;
                n_state         = i_sts.walk_done ? S_CHECK : S_WALK_RD;
            end
            S_CHECK: begin
                if (i_sts.full) begin
                    o_cmd.res = RES_FULL;
                    n_state   = S_FINISH;
                end else begin
                    o_cmd.setup_move = 1'b1;
                    n_state          = S_MOVE_RD;
                end
            end
            S_MOVE_RD: begin
                if (i_sts.move_done) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.span_rd = 1'b1;
                    n_state       = S_MOVE_WR;
                end
            end
            S_MOVE_WR: begin
                o_cmd.move_wr = 1'b1;
                n_state       = S_MOVE_RD;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                o_cmd.res    = RES_ADD;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/hsm_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "heightfield_span_merge_core_assert.svh"

module hsm_dpath
    import hsm_pkg::*;
#(
    parameter int GRID_W      = 64,
    parameter int GRID_H      = 64,
    parameter int MAX_SPANS   = 8,
    parameter int HEIGHT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic [9:0]  i_cfg_data,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic        i_action,
    input  wire logic [5:0]  i_col_x,
    input  wire logic [5:0]  i_col_z,
    input  wire logic [15:0] i_span_bottom,
    input  wire logic [15:0] i_span_top,
    input  wire logic [5:0]  i_area_id,
    input  wire logic [2:0]  i_slot,
    input  wire logic        i_out_stall,
    output logic             o_out_valid,
    output logic [1:0]       o_status,
    output logic [15:0]      o_out_bottom,
    output logic [15:0]      o_out_top,
    output logic [5:0]       o_out_area,
    output logic [2:0]       o_out_slot,
    output logic [3:0]       o_span_count
);

    localparam int HB         = HEIGHT_BITS;
    localparam int NUM_COLS   = GRID_W * GRID_H;
    localparam int COL_BITS   = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
    localparam int SPAN_DEPTH = NUM_COLS * MAX_SPANS;
    localparam int ADDR_BITS  = (SPAN_DEPTH > 1) ? $clog2(SPAN_DEPTH) : 1;
    localparam int CNT_BITS   = $clog2(MAX_SPANS + 1);
    localparam int NW         = CNT_BITS + 1;
    localparam int SPAN_W     = 2 * HB + 6;

    // Configuration
    logic [9:0]          r_thr;

    // Current item and merged span
    logic                r_action;
    logic [5:0]          r_x;
    logic [5:0]          r_z;
    logic [HB-1:0]       r_bot;
    logic [HB-1:0]       r_top;
    logic [5:0]          r_area;
    logic [2:0]          r_slot;
    logic [COL_BITS-1:0] r_ci;
    logic [ADDR_BITS-1:0] r_base;
    logic [CNT_BITS-1:0] r_cnt;

    // Coordinates wrapped to the grid
    logic [5:0]          w_x_wrap;
    logic [5:0]          w_z_wrap;

    // Walk and move bookkeeping
    logic [CNT_BITS-1:0] r_idx;
    logic [CNT_BITS-1:0] r_first;
    logic [CNT_BITS-1:0] r_j;
    logic                r_merging;
    logic [CNT_BITS-1:0] r_dst;
    logic [CNT_BITS-1:0] r_nmov;
    logic                r_up;
    logic [CNT_BITS-1:0] r_newcnt;
    logic [COL_BITS-1:0] r_clr;

    // Working result
    logic [1:0]          r_st;
    logic [HB-1:0]       r_rb;
    logic [HB-1:0]       r_rt;
    logic [5:0]          r_ra;
    logic [2:0]          r_rslot;
    logic [CNT_BITS-1:0] r_rcnt;

    // Output register
    logic                r_ov;
    logic [1:0]          r_o_st;
    logic [HB-1:0]       r_o_b;
    logic [HB-1:0]       r_o_t;
    logic [5:0]          r_o_a;
    logic [2:0]          r_o_slot;
    logic [CNT_BITS-1:0] r_o_cnt;

    // Memory ports
    logic [CNT_BITS-1:0]  cnt_rdata;
    logic                 cnt_we;
    logic [COL_BITS-1:0]  cnt_waddr;
    logic [CNT_BITS-1:0]  cnt_wdata;
    logic [SPAN_W-1:0]    span_rdata;
    logic                 span_we;
    logic [ADDR_BITS-1:0] span_waddr;
    logic [SPAN_W-1:0]    span_wdata;
    logic [ADDR_BITS-1:0] span_raddr;

    // Walk evaluation of the span just read
    logic [HB-1:0]       w_rb;
    logic [HB-1:0]       w_rt;
    logic [5:0]          w_ra;
    logic                w_skip;
    logic                w_hit;
    logic [HB-1:0]       w_nb;
    logic [HB-1:0]       w_nt;
    logic [HB-1:0]       w_diff;
    logic                w_take;
    logic [CNT_BITS-1:0] w_idx_inc;
    logic [NW-1:0]       w_nc;

    // The coordinates are six bits wide, so the wrap is a small constant lookup.
    always_comb begin
        w_x_wrap = '0;
        w_z_wrap = '0;
        for (int k = 0; k < 64; k++) begin
            if (i_col_x == 6'(k)) begin
                w_x_wrap = 6'(k % GRID_W);
            end
            if (i_col_z == 6'(k)) begin
                w_z_wrap = 6'(k % GRID_H);
            end
        end
    end

    assign {w_rb, w_rt, w_ra} = span_rdata;

    // Before the merge starts, spans entirely below the new bottom are skipped.
    assign w_skip    = !r_merging && (w_rt < r_bot);
    assign w_hit     = !w_skip && (w_rb <= r_top);
    assign w_nb      = (w_rb < r_bot) ? w_rb : r_bot;
    assign w_nt      = (w_rt > r_top) ? w_rt : r_top;
    assign w_diff    = w_nt - w_rt;
    assign w_take    = (17'(w_diff) <= 17'(r_thr)) && (w_ra > r_area);
    assign w_idx_inc = r_idx + 1'b1;
    assign w_nc      = NW'(r_cnt) + NW'(1) - (NW'(r_j) - NW'(r_first));

    always_comb begin
        o_sts.clear_last = (r_clr == COL_BITS'(NUM_COLS - 1));
        o_sts.is_read    = (r_action == ACT_READ);
        o_sts.slot_empty = (6'(r_slot) >= 6'(r_cnt));
        o_sts.bad_order  = (r_bot > r_top);
        o_sts.cnt_zero   = (r_cnt == '0);
        o_sts.walk_done  = !(w_skip || w_hit) || (w_idx_inc == r_cnt);
        o_sts.full       = (w_nc > NW'(MAX_SPANS));
        o_sts.move_done  = (r_nmov == '0);
        o_sts.out_free   = !r_ov || !i_out_stall;
    end

    // Column counts; the clearing pass after reset zeroes every entry.
    assign cnt_we    = i_cmd.clear_step || i_cmd.commit;
    assign cnt_waddr = i_cmd.clear_step ? r_clr : r_ci;
    assign cnt_wdata = i_cmd.clear_step ? '0 : r_newcnt;

    hsm_ram #(
        .WIDTH (CNT_BITS),
        .DEPTH (NUM_COLS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (i_cmd.cnt_rd),
        .i_raddr (r_ci),
        .o_rdata (cnt_rdata)
    );

    assign span_raddr = r_base + ADDR_BITS'(r_idx);
    assign span_we    = i_cmd.commit || i_cmd.move_wr;
    assign span_waddr = i_cmd.commit ? (r_base + ADDR_BITS'(r_first))
                                     : (r_base + ADDR_BITS'(r_dst));
    assign span_wdata = i_cmd.commit ? {r_bot, r_top, r_area} : span_rdata;

    hsm_ram #(
        .WIDTH (SPAN_W),
        .DEPTH (SPAN_DEPTH)
    ) u_span_ram (
        .i_clk   (i_clk),
        .i_we    (span_we),
        .i_waddr (span_waddr),
        .i_wdata (span_wdata),
        .i_re    (i_cmd.span_rd),
        .i_raddr (span_raddr),
        .o_rdata (span_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 10'd1;
            r_clr <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Item, walk and move registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action  <= i_action;
            r_x       <= w_x_wrap;
            r_z       <= w_z_wrap;
            r_bot     <= i_span_bottom[HB-1:0];
            r_top     <= i_span_top[HB-1:0];
            r_area    <= i_area_id;
            r_slot    <= i_slot;
            r_idx     <= (i_action == ACT_READ) ? CNT_BITS'(i_slot) : '0;
            r_first   <= '0;
            r_j       <= '0;
            r_merging <= 1'b0;
        end
        if (i_cmd.col_calc) begin
            r_ci <= COL_BITS'(r_x) + COL_BITS'(r_z) * COL_BITS'(GRID_W);
        end
        if (i_cmd.cnt_rd) begin
            r_base <= ADDR_BITS'(r_ci) * ADDR_BITS'(MAX_SPANS);
        end
        if (i_cmd.cnt_get) begin
            r_cnt <= cnt_rdata;
        end
        if (i_cmd.walk_eval) begin
            if (w_skip) begin
                r_first <= w_idx_inc;
                r_j     <= w_idx_inc;
                r_idx   <= w_idx_inc;
            end else if (w_hit) begin
                r_bot     <= w_nb;
                r_top     <= w_nt;
                if (w_take) begin
                    r_area <= w_ra;
                end
                r_merging <= 1'b1;
                r_j       <= w_idx_inc;
                r_idx     <= w_idx_inc;
            end
        end
        if (i_cmd.setup_move) begin
            r_newcnt <= w_nc[CNT_BITS-1:0];
            if (r_j == r_first) begin
                // Nothing absorbed: open a hole at the insert point.
                r_up   <= 1'b1;
                r_idx  <= r_cnt - 1'b1;
                r_dst  <= r_cnt;
                r_nmov <= r_cnt - r_first;
            end else if (r_j == r_first + 1'b1) begin
                r_nmov <= '0;
            end else begin
                // Several spans absorbed: close the gap above the insert point.
                r_up   <= 1'b0;
                r_idx  <= r_j;
                r_dst  <= r_first + 1'b1;
                r_nmov <= r_cnt - r_j;
            end
        end
        if (i_cmd.move_wr) begin
            r_idx  <= r_up ? (r_idx - 1'b1) : (r_idx + 1'b1);
            r_dst  <= r_up ? (r_dst - 1'b1) : (r_dst + 1'b1);
            r_nmov <= r_nmov - 1'b1;
        end
    end

    // Working result
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.res)
            RES_NONE: begin
            end
            RES_EMPTY: begin
                r_st    <= ST_EMPTY;
                r_rb    <= '0;
                r_rt    <= '0;
                r_ra    <= '0;
                r_rslot <= r_slot;
                r_rcnt  <= r_cnt;
            end
            RES_READ: begin
                r_st    <= ST_OK;
                r_rb    <= w_rb;
                r_rt    <= w_rt;
                r_ra    <= w_ra;
                r_rslot <= r_slot;
                r_rcnt  <= r_cnt;
            end
            RES_ORDER: begin
                r_st    <= ST_ORDER;
                r_rb    <= '0;
                r_rt    <= '0;
                r_ra    <= '0;
                r_rslot <= '0;
                r_rcnt  <= r_cnt;
            end
            RES_FULL: begin
                r_st    <= ST_FULL;
                r_rb    <= '0;
                r_rt    <= '0;
                r_ra    <= '0;
                r_rslot <= '0;
                r_rcnt  <= r_cnt;
            end
            RES_ADD: begin
                r_st    <= ST_OK;
                r_rb    <= r_bot;
                r_rt    <= r_top;
                r_ra    <= r_area;
                r_rslot <= 3'(r_first);
                r_rcnt  <= r_newcnt;
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_st   <= r_st;
            r_o_b    <= r_rb;
            r_o_t    <= r_rt;
            r_o_a    <= r_ra;
            r_o_slot <= r_rslot;
            r_o_cnt  <= r_rcnt;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_status     = r_o_st;
    assign o_out_bottom = 16'(r_o_b);
    assign o_out_top    = 16'(r_o_t);
    assign o_out_area   = r_o_a;
    assign o_out_slot   = r_o_slot;
    assign o_span_count = 4'(r_o_cnt);

    `HSM_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, r_ov && i_out_stall, !i_cmd.out_load)
    `HSM_ASSERT_IMP(a_walk_in_range, i_clk, i_rst_n, i_cmd.walk_eval, r_idx < r_cnt)
    `HSM_ASSERT_IMP(a_merge_window, i_clk, i_rst_n, i_cmd.setup_move,
                    (r_first <= r_j) && (r_j <= r_cnt))
    `HSM_ASSERT_IMP(a_commit_count, i_clk, i_rst_n, i_cmd.commit,
                    (r_newcnt != '0) && (NW'(r_newcnt) <= NW'(MAX_SPANS)))
    `HSM_ASSERT_NXT(a_result_count, i_clk, i_rst_n, i_cmd.commit,
                    (r_st == ST_OK) && (r_rcnt == $past(r_newcnt)))

endmodule

`default_nettype wire
